FILE: rtl/icr_pkg.sv
package icr_pkg;

  localparam int QuotW = 64;
  localparam int DivW  = 33;

  localparam logic [1:0] OUT_IMPULSE  = 2'd0;
  localparam logic [1:0] OUT_SEPARATE = 2'd1;
  localparam logic [1:0] OUT_STATIC   = 2'd2;

  localparam logic [15:0] BOUNCE_ONE = 16'd32768;

  typedef struct packed {
    logic signed [31:0] vax;
    logic signed [31:0] vay;
    logic signed [31:0] vbx;
    logic signed [31:0] vby;
    logic signed [15:0] nx;
    logic signed [15:0] ny;
    logic [31:0]        inva;
    logic [31:0]        invb;
    logic [1:0]         outcome;
  } ctx_t;

endpackage

FILE: rtl/icr_front.sv
module icr_front
  import icr_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        en,
  input  logic        in_valid,
  input  ctx_t        in_ctx,
  input  logic [15:0] in_ea,
  input  logic [15:0] in_eb,
  output logic        out_valid,
  output ctx_t        out_ctx,
  output logic [63:0] out_num,
  output logic [32:0] out_sum
);

  logic               v1_r, v2_r, v3_r, v4_r;
  ctx_t               c1_r, c2_r, c3_r, c4_r;
  logic signed [32:0] rx1_r, ry1_r;
  logic [32:0]        s1_r, s2_r, s3_r, s4_r;
  logic [16:0]        ep1_r, ep2_r, ep3_r;
  logic signed [48:0] px2_r, py2_r;
  logic [49:0]        ndot3_r;
  logic [63:0]        num4_r;

  logic [15:0]        ea_sat, eb_sat, e_min;
  logic signed [49:0] dot;
  logic [49:0]        ndot;
  logic [1:0]         outc;
  logic [66:0]        num_full;
  ctx_t               c2_upd;

  assign ea_sat = (in_ea > BOUNCE_ONE) ? BOUNCE_ONE : in_ea;
  assign eb_sat = (in_eb > BOUNCE_ONE) ? BOUNCE_ONE : in_eb;
  assign e_min  = (ea_sat < eb_sat) ? ea_sat : eb_sat;

  assign dot  = 50'(px2_r) + 50'(py2_r);
  assign ndot = 50'(-dot);
  assign num_full = 67'(ndot3_r) * 67'(ep3_r);

  always_comb begin
    if (dot > 50'sd0) begin
      outc = OUT_SEPARATE;
    end else if (s2_r == 33'd0) begin
      outc = OUT_STATIC;
    end else begin
      outc = OUT_IMPULSE;
    end
  end

  always_comb begin
    c2_upd         = c2_r;
    c2_upd.outcome = outc;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      c1_r  <= in_ctx;
      rx1_r <= 33'(in_ctx.vbx) - 33'(in_ctx.vax);
      ry1_r <= 33'(in_ctx.vby) - 33'(in_ctx.vay);
      s1_r  <= {1'b0, in_ctx.inva} + {1'b0, in_ctx.invb};
      ep1_r <= {1'b0, BOUNCE_ONE} + {1'b0, e_min};

      c2_r  <= c1_r;
      px2_r <= 49'(rx1_r) * 49'(c1_r.nx);
      py2_r <= 49'(ry1_r) * 49'(c1_r.ny);
      s2_r  <= s1_r;
      ep2_r <= ep1_r;

      c3_r    <= c2_upd;
      ndot3_r <= ndot;
      s3_r    <= s2_r;
      ep3_r   <= ep2_r;

      c4_r   <= c3_r;
      num4_r <= num_full[63:0];
      s4_r   <= s3_r;
    end
  end

  assign out_valid = v4_r;
  assign out_ctx   = c4_r;
  assign out_num   = num4_r;
  assign out_sum   = s4_r;

endmodule

FILE: rtl/icr_div.sv
module icr_div
  import icr_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        en,
  input  logic        in_valid,
  input  ctx_t        in_ctx,
  input  logic [63:0] in_num,
  input  logic [32:0] in_sum,
  output logic        out_valid,
  output ctx_t        out_ctx,
  output logic [63:0] out_quot
);

  logic [DivW+QuotW-1:0] rq_r [QuotW];
  logic [DivW-1:0]       sd_r [QuotW];
  ctx_t                  cx_r [QuotW];
  logic                  vl_r [QuotW];

  for (genvar g = 0; g < QuotW; g++) begin : g_step
    logic [DivW+QuotW-1:0] src;
    logic [DivW-1:0]       den;
    ctx_t                  cin;
    logic                  vin;
    logic [DivW:0]         trial;
    logic                  ge;
    logic [DivW:0]         rem;

    if (g == 0) begin : g_first
      assign src = {{DivW{1'b0}}, in_num};
      assign den = in_sum;
      assign cin = in_ctx;
      assign vin = in_valid;
    end else begin : g_next
      assign src = rq_r[g-1];
      assign den = sd_r[g-1];
      assign cin = cx_r[g-1];
      assign vin = vl_r[g-1];
    end

    assign trial = {src[DivW+QuotW-1:QuotW], src[QuotW-1]};
    assign ge    = trial >= {1'b0, den};
    assign rem   = ge ? (trial - {1'b0, den}) : trial;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vl_r[g] <= 1'b0;
      end else if (en) begin
        vl_r[g] <= vin;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rq_r[g] <= {rem[DivW-1:0], src[QuotW-2:0], ge};
        sd_r[g] <= den;
        cx_r[g] <= cin;
      end
    end
  end

  assign out_valid = vl_r[QuotW-1];
  assign out_ctx   = cx_r[QuotW-1];
  assign out_quot  = rq_r[QuotW-1][QuotW-1:0];

endmodule

FILE: rtl/icr_apply.sv
module icr_apply
  import icr_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         en,
  input  logic         in_valid,
  input  ctx_t         in_ctx,
  input  logic [63:0]  in_quot,
  output logic         out_valid,
  output logic [127:0] out_vel,
  output logic [1:0]   out_outcome,
  output logic         out_clipped
);

  logic        va_r, vb_r, vc_r, vd_r;
  ctx_t        ca_r, cb_r, cc_r;
  logic [63:0] ja_r;
  logic [1:0]  outc_r;
  logic [3:0]  clip_r;
  logic [31:0] res_r [4];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
      vb_r <= 1'b0;
      vc_r <= 1'b0;
      vd_r <= 1'b0;
    end else if (en) begin
      va_r <= in_valid;
      vb_r <= va_r;
      vc_r <= vb_r;
      vd_r <= vc_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ca_r   <= in_ctx;
      ja_r   <= in_quot;
      cb_r   <= ca_r;
      cc_r   <= cb_r;
      outc_r <= cc_r.outcome;
    end
  end

  for (genvar k = 0; k < 4; k++) begin : g_lane
    logic signed [15:0]  n_in;
    logic [31:0]         inv_in;
    logic signed [31:0]  v_cc;
    logic                neg_cc;
    logic [15:0]         nmag;
    logic [47:0]         w_r;
    logic [63:0]         pll_r, phl_r;
    logic [47:0]         plh_r, phh_r;
    logic [111:0]        prod;
    logic [33:0]         delta_r;
    logic                add;
    logic signed [35:0]  sum;
    logic [31:0]         res;
    logic                clip;

    assign n_in   = (k % 2 == 0) ? in_ctx.nx : in_ctx.ny;
    assign inv_in = (k < 2) ? in_ctx.inva : in_ctx.invb;
    assign nmag   = n_in[15] ? 16'(-n_in) : n_in;
    assign neg_cc = (k % 2 == 0) ? cc_r.nx[15] : cc_r.ny[15];
    assign add    = (k < 2) ? neg_cc : !neg_cc;

    always_comb begin
      case (k)
        0:       v_cc = cc_r.vax;
        1:       v_cc = cc_r.vay;
        2:       v_cc = cc_r.vbx;
        default: v_cc = cc_r.vby;
      endcase
    end

    assign prod = 112'(pll_r) + (112'(plh_r) << 32) + (112'(phl_r) << 32)
                + (112'(phh_r) << 64);
    assign sum  = add ? (36'(v_cc) + 36'(delta_r)) : (36'(v_cc) - 36'(delta_r));

    always_comb begin
      clip = 1'b0;
      res  = sum[31:0];
      if (cc_r.outcome != OUT_IMPULSE) begin
        res = v_cc;
      end else if (sum > 36'sh0_7FFF_FFFF) begin
        res  = 32'h7FFF_FFFF;
        clip = 1'b1;
      end else if (sum < -36'sh0_8000_0000) begin
        res  = 32'h8000_0000;
        clip = 1'b1;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        w_r   <= 48'(inv_in) * 48'(nmag);
        pll_r <= 64'(ja_r[31:0]) * 64'(w_r[31:0]);
        plh_r <= 48'(ja_r[31:0]) * 48'(w_r[47:32]);
        phl_r <= 64'(ja_r[63:32]) * 64'(w_r[31:0]);
        phh_r <= 48'(ja_r[63:32]) * 48'(w_r[47:32]);
        delta_r <= (|prod[111:76]) ? 34'h2_0000_0000 : {1'b0, prod[75:43]};
        res_r[k]  <= res;
        clip_r[k] <= clip;
      end
    end
  end

  assign out_valid   = vd_r;
  assign out_vel     = {res_r[3], res_r[2], res_r[1], res_r[0]};
  assign out_outcome = outc_r;
  assign out_clipped = |clip_r;

endmodule

FILE: rtl/impulse_collision_response.sv
// Channel   Direction  Handshake                Payload
// in_       slave      in_tvalid / in_tready    in_tdata: one contact
// out_      master     out_tvalid / out_tready  out_tdata: velocities, out_tuser: flags
//
// One contact enters per cycle unless the output stalls; its result passes through
// the 64 stage restoring divider that forms the impulse one quotient bit a stage.
// Four front stages and four multiply and saturate stages surround it.
// Reset clears only the stage valid bits. A stall on the output freezes the
// whole pipeline, so no item is lost or repeated.
module impulse_collision_response
  import icr_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // body_a_vel_x, body_a_vel_y, body_b_vel_x, body_b_vel_y, normal_x,
  // normal_y, body_a_inv_mass, body_b_inv_mass, body_a_bounce, body_b_bounce
  input  logic [255:0] in_tdata,
  output logic         out_tvalid,
  input  logic         out_tready,
  // new_a_vel_x, new_a_vel_y, new_b_vel_x, new_b_vel_y
  output logic [127:0] out_tdata,
  // outcome, clipped
  output logic [2:0]   out_tuser
);

  logic        en;
  ctx_t        in_ctx, f_ctx, d_ctx;
  logic        f_valid, d_valid;
  logic [63:0] f_num, d_quot;
  logic [32:0] f_sum;
  logic [1:0]  outcome;
  logic        clipped;

  assign en        = out_tready || !out_tvalid;
  assign in_tready = en;

  assign in_ctx.vax     = in_tdata[31:0];
  assign in_ctx.vay     = in_tdata[63:32];
  assign in_ctx.vbx     = in_tdata[95:64];
  assign in_ctx.vby     = in_tdata[127:96];
  assign in_ctx.nx      = in_tdata[143:128];
  assign in_ctx.ny      = in_tdata[159:144];
  assign in_ctx.inva    = in_tdata[191:160];
  assign in_ctx.invb    = in_tdata[223:192];
  assign in_ctx.outcome = OUT_IMPULSE;

  icr_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (in_tvalid),
    .in_ctx    (in_ctx),
    .in_ea     (in_tdata[239:224]),
    .in_eb     (in_tdata[255:240]),
    .out_valid (f_valid),
    .out_ctx   (f_ctx),
    .out_num   (f_num),
    .out_sum   (f_sum)
  );

  icr_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (f_valid),
    .in_ctx    (f_ctx),
    .in_num    (f_num),
    .in_sum    (f_sum),
    .out_valid (d_valid),
    .out_ctx   (d_ctx),
    .out_quot  (d_quot)
  );

  icr_apply u_apply (
    .clk         (clk),
    .rst_n       (rst_n),
    .en          (en),
    .in_valid    (d_valid),
    .in_ctx      (d_ctx),
    .in_quot     (d_quot),
    .out_valid   (out_tvalid),
    .out_vel     (out_tdata),
    .out_outcome (outcome),
    .out_clipped (clipped)
  );

  assign out_tuser = {clipped, outcome};

endmodule
